>>> src/bbm_pkg.sv
// Shared types and constants of the binary brick morphology block.
package bbm_pkg;

  localparam int WORD_W  = 32;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 13;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [1:0] OP_DILATE = 2'd0;
  localparam logic [1:0] OP_ERODE  = 2'd1;
  localparam logic [1:0] OP_OPEN   = 2'd2;
  localparam logic [1:0] OP_CLOSE  = 2'd3;

  typedef enum logic [CFG_IW-1:0] {
    REG_OP_MODE     = 3'd0,
    REG_WIDTH_PX    = 3'd1,
    REG_HEIGHT_ROWS = 3'd2,
    REG_H_HALF      = 3'd3,
    REG_V_HALF      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MID_CHECK,
    SQ_MID_WAIT,
    SQ_OUT_CHECK,
    SQ_OUT_WAIT,
    SQ_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } stg_state_t;

  typedef struct packed {
    logic start;
    logic inv;
  } stage_ctl_t;

  typedef struct packed {
    logic  done;
    word_t word;
  } stage_rsp_t;

endpackage

>>> src/bbm_if.sv
// Stream channel interfaces of the binary brick morphology block.
interface bbm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] pixel_word;
  modport source (output valid, output req_type, output pixel_word, input ready);
  modport sink (input valid, input req_type, input pixel_word, output ready);
endinterface

interface bbm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        row_end;
  logic        frame_end;
  modport source (output valid, output out_word, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input out_word, input row_end, input frame_end,
                output ready);
endinterface

>>> src/binary_brick_morphology.sv
// Binary brick morphology: rectangular-window dilate, erode, open and close on packed 1-bit images.
// The block takes a 1-bit image in raster order as 32-pixel words (bit 31 leftmost) and
// returns the dilated, eroded, opened or closed image with a window of 2*h_half+1 columns
// by 2*v_half+1 rows. A stage makes a word once its source holds the word at the lower
// right corner of its window, so each stage trails its source by v_half rows plus one
// word; flush transfers (req_type 1) push the last words out. The block works on one
// input transfer at a time. Each stage walks its window with one read of its row store
// per cycle: the left, centre and right words of each of the 2*v_half+1 rows, top row
// first, then it drains the read pipeline (ST_DRAIN) and hands back the word (ST_DONE).
// Around it the sequencer checks and waits on the first stage, then on the second stage
// for open and close, and emits the result, which waits until the output register is free.
// Configuration writes abort any frame in progress.
module binary_brick_morphology #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_HALF   = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  bbm_in_if.sink                       in_ch,
  bbm_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [bbm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bbm_pkg::CFG_DW-1:0]   cfg_data
);
  import bbm_pkg::*;

  localparam int WM   = (MAX_WIDTH + 31) / 32;
  localparam int RING = 2 * MAX_HALF + 2;
  localparam int CW   = $clog2(WM + 1);
  localparam int GW   = $clog2(RING);
  localparam int HTW  = $clog2(MAX_HEIGHT + 1);
  localparam int HW   = $clog2(MAX_HALF + 1);
  localparam int WPXW = $clog2(MAX_WIDTH + 1);
  localparam int POSW = $clog2(WM * MAX_HEIGHT + 1);

  // Configuration registers, kept saturated to their legal ranges.
  logic [1:0]      op_mode;
  logic [WPXW-1:0] width_px;
  logic [HTW-1:0]  height_rows;
  logic [HW-1:0]   h_half, v_half;

  // Positions: words taken in, first-stage words made, words given out.
  logic [POSW-1:0] in_pos, mid_pos, out_pos;
  logic [CW-1:0]   in_col, mid_col, out_col;
  logic [GW-1:0]   in_ring, mid_ring, out_ring;
  logic [HTW-1:0]  mid_row, out_row;

  seq_state_t state, state_next;
  logic have, res_row_end, res_frame_end;
  word_t res_word;

  logic [CW-1:0]   words;
  logic [POSW-1:0] total;
  logic [POSW:0]   vw;
  logic [POSW:0]   need_mid, need_out;
  word_t           last_mask;
  logic [WPXW-1:0] wm1;
  logic two, accept, take_in, out_free;
  logic cfg_hit, emit;

  stage_ctl_t s1_ctl, s2_ctl;
  stage_rsp_t s1_rsp, s2_rsp;
  logic s2_wr;

  logic [11:0] cw12;
  logic [12:0] ch13;
  logic [3:0]  chh;

  // Geometry derived from the registers.
  always_comb begin
    words     = CW'((({1'b0, width_px}) + (WPXW+1)'(31)) >> 5);
    total     = POSW'(words) * POSW'(height_rows);
    vw        = (POSW+1)'(v_half) * (POSW+1)'(words);
    wm1       = width_px - WPXW'(1);
    last_mask = '1 << (5'd31 - wm1[4:0]);
    need_mid  = (POSW+1)'(mid_pos) + vw + (POSW+1)'(2);
    if (need_mid > (POSW+1)'(total)) need_mid = (POSW+1)'(total);
    need_out  = (POSW+1)'(out_pos) + vw + (POSW+1)'(2);
    if (need_out > (POSW+1)'(total)) need_out = (POSW+1)'(total);
    two       = (op_mode == OP_OPEN) || (op_mode == OP_CLOSE);
  end

  assign in_ch.ready = (state == SQ_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // Surplus image words past the end of the frame act as flush transfers.
  assign take_in     = accept && !in_ch.req_type && (in_pos < total);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign cfg_hit     = cfg_we && (cfg_index <= REG_V_HALF);
  // The waiting result moves into the output register in this cycle.
  assign emit        = (state == SQ_EMIT) && have && out_free && !cfg_hit;

  always_comb begin
    s1_ctl.start = (state == SQ_MID_CHECK) && (mid_pos < total) &&
                   ((POSW+1)'(in_pos) >= need_mid);
    s1_ctl.inv   = (op_mode == OP_ERODE) || (op_mode == OP_OPEN);
    s2_ctl.start = (state == SQ_OUT_CHECK) && two && (out_pos < total) &&
                   ((POSW+1)'(mid_pos) >= need_out);
    s2_ctl.inv   = (op_mode == OP_CLOSE);
    s2_wr        = (state == SQ_MID_WAIT) && s1_rsp.done && two;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE:      if (accept) state_next = SQ_MID_CHECK;
      SQ_MID_CHECK: state_next = s1_ctl.start ? SQ_MID_WAIT : SQ_OUT_CHECK;
      SQ_MID_WAIT:  if (s1_rsp.done) state_next = SQ_OUT_CHECK;
      SQ_OUT_CHECK: state_next = s2_ctl.start ? SQ_OUT_WAIT : SQ_EMIT;
      SQ_OUT_WAIT:  if (s2_rsp.done) state_next = SQ_EMIT;
      SQ_EMIT:      if (!have || out_free) state_next = SQ_IDLE;
      default:      state_next = SQ_IDLE;
    endcase
  end

  assign cw12 = cfg_data[11:0];
  assign ch13 = cfg_data[12:0];
  assign chh  = cfg_data[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SQ_IDLE;
      op_mode     <= OP_DILATE;
      width_px    <= WPXW'(MAX_WIDTH);
      height_rows <= HTW'(1);
      h_half      <= '0;
      v_half      <= '0;
      in_pos  <= '0; in_col  <= '0; in_ring  <= '0;
      mid_pos <= '0; mid_col <= '0; mid_ring <= '0; mid_row <= '0;
      out_pos <= '0; out_col <= '0; out_ring <= '0; out_row <= '0;
      have         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready && !emit) out_ch.valid <= 1'b0;

      if (cfg_hit) begin
        unique case (cfg_index)
          REG_OP_MODE:  op_mode <= cfg_data[1:0];
          REG_WIDTH_PX: begin
            if (cw12 == 12'd0) width_px <= WPXW'(1);
            else if (32'(cw12) > MAX_WIDTH) width_px <= WPXW'(MAX_WIDTH);
            else width_px <= WPXW'(cw12);
          end
          REG_HEIGHT_ROWS: begin
            if (ch13 == 13'd0) height_rows <= HTW'(1);
            else if (32'(ch13) > MAX_HEIGHT) height_rows <= HTW'(MAX_HEIGHT);
            else height_rows <= HTW'(ch13);
          end
          REG_H_HALF: h_half <= (32'(chh) > MAX_HALF) ? HW'(MAX_HALF) : HW'(chh);
          default:    v_half <= (32'(chh) > MAX_HALF) ? HW'(MAX_HALF) : HW'(chh);
        endcase
        in_pos  <= '0; in_col  <= '0; in_ring  <= '0;
        mid_pos <= '0; mid_col <= '0; mid_ring <= '0; mid_row <= '0;
        out_pos <= '0; out_col <= '0; out_ring <= '0; out_row <= '0;
      end else begin
        if (state == SQ_IDLE) have <= 1'b0;

        if (take_in) begin
          in_pos <= in_pos + POSW'(1);
          if (in_col == words - CW'(1)) begin
            in_col  <= '0;
            in_ring <= (32'(in_ring) == RING - 1) ? '0 : in_ring + GW'(1);
          end else begin
            in_col <= in_col + CW'(1);
          end
        end

        // A first-stage word is either the result or goes to the second row store.
        if (state == SQ_MID_WAIT && s1_rsp.done) begin
          if (!two) begin
            have          <= 1'b1;
            res_word      <= s1_rsp.word;
            res_row_end   <= (mid_col == words - CW'(1));
            res_frame_end <= (mid_pos + POSW'(1) == total);
          end
          mid_pos <= mid_pos + POSW'(1);
          if (mid_col == words - CW'(1)) begin
            mid_col  <= '0;
            mid_row  <= mid_row + HTW'(1);
            mid_ring <= (32'(mid_ring) == RING - 1) ? '0 : mid_ring + GW'(1);
          end else begin
            mid_col <= mid_col + CW'(1);
          end
        end

        if (state == SQ_OUT_WAIT && s2_rsp.done) begin
          have          <= 1'b1;
          res_word      <= s2_rsp.word;
          res_row_end   <= (out_col == words - CW'(1));
          res_frame_end <= (out_pos + POSW'(1) == total);
          out_pos <= out_pos + POSW'(1);
          if (out_col == words - CW'(1)) begin
            out_col  <= '0;
            out_row  <= out_row + HTW'(1);
            out_ring <= (32'(out_ring) == RING - 1) ? '0 : out_ring + GW'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end

        // The result transfer; the last word of the image rewinds every position.
        if (emit) begin
          out_ch.valid     <= 1'b1;
          out_ch.out_word  <= res_word;
          out_ch.row_end   <= res_row_end;
          out_ch.frame_end <= res_frame_end;
          have             <= 1'b0;
          if (res_frame_end) begin
            in_pos  <= '0; in_col  <= '0; in_ring  <= '0;
            mid_pos <= '0; mid_col <= '0; mid_ring <= '0; mid_row <= '0;
            out_pos <= '0; out_col <= '0; out_ring <= '0; out_row <= '0;
          end
        end
      end
    end
  end

  bbm_stage #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_HALF(MAX_HALF)) u_first (
    .clk(clk), .rst(rst), .ctl(s1_ctl),
    .row(mid_row), .col(mid_col), .ring(mid_ring),
    .words(words), .height(height_rows), .h_half(h_half), .v_half(v_half),
    .last_mask(last_mask),
    .wr_en(take_in), .wr_ring(in_ring), .wr_col(in_col), .wr_data(in_ch.pixel_word),
    .rsp(s1_rsp)
  );

  bbm_stage #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_HALF(MAX_HALF)) u_second (
    .clk(clk), .rst(rst), .ctl(s2_ctl),
    .row(out_row), .col(out_col), .ring(out_ring),
    .words(words), .height(height_rows), .h_half(h_half), .v_half(v_half),
    .last_mask(last_mask),
    .wr_en(s2_wr), .wr_ring(mid_ring), .wr_col(mid_col), .wr_data(s1_rsp.word),
    .rsp(s2_rsp)
  );
endmodule

>>> src/bbm_cell.sv
// One cell of the horizontal dilation chain: adds the neighbors at one shift distance.
module bbm_cell #(
  parameter int SHIFT = 1
) (
  input  bbm_pkg::word_t l,
  input  bbm_pkg::word_t c,
  input  bbm_pkg::word_t r,
  input  logic           en,
  input  bbm_pkg::word_t acc_in,
  output bbm_pkg::word_t acc_out
);
  import bbm_pkg::*;

  word_t spread;

  assign spread = (c << SHIFT) | (r >> (WORD_W - SHIFT)) |
                  (c >> SHIFT) | (l << (WORD_W - SHIFT));
  assign acc_out = en ? (acc_in | spread) : acc_in;
endmodule

>>> src/bbm_stage.sv
// One morphology stage: its row store and the sequencer that gathers one window.
module bbm_stage #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_HALF   = 15,
  localparam int WM   = (MAX_WIDTH + 31) / 32,
  localparam int RING = 2 * MAX_HALF + 2,
  localparam int CW   = $clog2(WM + 1),
  localparam int GW   = $clog2(RING),
  localparam int HTW  = $clog2(MAX_HEIGHT + 1),
  localparam int HW   = $clog2(MAX_HALF + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  bbm_pkg::stage_ctl_t ctl,
  input  logic [HTW-1:0]      row,
  input  logic [CW-1:0]       col,
  input  logic [GW-1:0]       ring,
  input  logic [CW-1:0]       words,
  input  logic [HTW-1:0]      height,
  input  logic [HW-1:0]       h_half,
  input  logic [HW-1:0]       v_half,
  input  bbm_pkg::word_t      last_mask,
  input  logic                wr_en,
  input  logic [GW-1:0]       wr_ring,
  input  logic [CW-1:0]       wr_col,
  input  bbm_pkg::word_t      wr_data,
  output bbm_pkg::stage_rsp_t rsp
);
  import bbm_pkg::*;

  localparam int DEPTH = RING * WM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = HW + 1;

  stg_state_t state, state_next;
  word_t mem [DEPTH];
  word_t q;
  logic [AW-1:0] raddr, waddr;

  logic signed [DW-1:0] dy;
  logic [1:0] tap;
  logic inv;
  word_t acc, lw, cw;

  logic signed [HTW+1:0] ysig;
  logic signed [CW+1:0]  jsig;
  logic signed [GW+1:0]  rsig, rwrap;
  logic row_ok, j_ok, last_issue;

  logic p_act, p_v, p_last;
  logic [1:0] p_tap;
  word_t dw;
  word_t chain [MAX_HALF+1];

  assign waddr = AW'(wr_ring) * AW'(WM) + AW'(wr_col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    q <= mem[raddr];
  end

  always_comb begin
    ysig   = $signed({2'b00, row}) + (HTW+2)'(dy);
    jsig   = $signed({2'b00, col}) + $signed({{CW{1'b0}}, tap}) - (CW+2)'(1);
    rsig   = $signed({2'b00, ring}) + (GW+2)'(dy);
    row_ok = (ysig >= 0) && (ysig < $signed({2'b00, height}));
    j_ok   = (jsig >= 0) && (jsig < $signed({2'b00, words}));
    if (rsig < 0) begin
      rwrap = rsig + (GW+2)'(RING);
    end else if (rsig >= (GW+2)'(RING)) begin
      rwrap = rsig - (GW+2)'(RING);
    end else begin
      rwrap = rsig;
    end
    raddr = (row_ok && j_ok) ? AW'(rwrap[GW-1:0]) * AW'(WM) + AW'(jsig[CW-1:0]) : '0;
    last_issue = (tap == 2'd2) && (dy == $signed({1'b0, v_half}));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (ctl.start) state_next = ST_READ;
      ST_READ:  if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      p_act <= 1'b0;
    end else begin
      state <= state_next;
      p_act <= (state == ST_READ);
    end
  end

  // Word as read, inverted for erosion and cut to the image width.
  assign dw = p_v ? ((inv ? ~q : q) & (p_last ? last_mask : '1)) : '0;

  assign chain[0] = cw;
  for (genvar s = 1; s <= MAX_HALF; s++) begin : g_cell
    bbm_cell #(.SHIFT(s)) u_cell (
      .l(lw), .c(cw), .r(dw),
      .en(h_half >= HW'(s)),
      .acc_in(chain[s-1]),
      .acc_out(chain[s])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && ctl.start) begin
      dy  <= -$signed({1'b0, v_half});
      tap <= 2'd0;
      acc <= '0;
      inv <= ctl.inv;
    end else if (state == ST_READ) begin
      if (tap == 2'd2) begin
        tap <= 2'd0;
        dy  <= dy + DW'(1);
      end else begin
        tap <= tap + 2'd1;
      end
    end
    p_v    <= row_ok && j_ok;
    p_tap  <= tap;
    p_last <= (jsig == $signed({2'b00, words}) - (CW+2)'(1));
    if (p_act) begin
      case (p_tap)
        2'd0:    lw <= dw;
        2'd1:    cw <= dw;
        default: acc <= acc | chain[MAX_HALF];
      endcase
    end
  end

  always_comb begin
    rsp.done = (state == ST_DONE);
    rsp.word = (inv ? ~acc : acc) & ((col == words - CW'(1)) ? last_mask : '1);
  end
endmodule
